[design/mcrt_pkg.sv]
// Shared constants, codes and types of the module chain remap table.
package mcrt_pkg;

    localparam int MAX_CONNECTED = 16;
    localparam int MAX_CACHED    = 32;

    localparam int SLOT_W      = (MAX_CACHED > 1) ? $clog2(MAX_CACHED) : 1;
    localparam int CONN_IDX_W  = (MAX_CONNECTED > 1) ? $clog2(MAX_CONNECTED) : 1;
    localparam int CONN_W      = $clog2(MAX_CONNECTED + 1);
    localparam int CACHE_CNT_W = $clog2(MAX_CACHED + 1);
    localparam int LOOP_W      = (CACHE_CNT_W > CONN_W) ? CACHE_CNT_W : CONN_W;

    localparam logic [7:0] ID_NONE  = 8'h00;
    localparam logic [7:0] ID_EMPTY = 8'hFF;

    typedef enum logic [2:0] {
        REQ_SCAN   = 3'd0,
        REQ_IN1    = 3'd1,
        REQ_IN2    = 3'd2,
        REQ_PUSH   = 3'd3,
        REQ_OUT    = 3'd4,
        REQ_QPOS   = 3'd5,
        REQ_QNTH   = 3'd6,
        REQ_NOP    = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_STROBE = 2'd2,
        KIND_ANSWER = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CW_NONE,
        CW_NEW,
        CW_IN1,
        CW_IN2,
        CW_OUT
    } cache_op_t;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] in1;
        logic [7:0] in2;
        logic [7:0] out;
    } cache_entry_t;

    typedef struct packed {
        cache_op_t         op;
        logic [SLOT_W-1:0] addr;
        logic [7:0]        data;
    } cache_wr_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] id_byte;
        logic [7:0] data_byte;
        logic [3:0] position;
        logic [3:0] occurrence;
    } req_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] shift_byte;
        logic       found;
        logic [7:0] answer_id;
        logic [7:0] answer_input_one;
        logic [7:0] answer_input_two;
        logic [7:0] answer_output;
        logic [4:0] connected_total;
        logic       error_flag;
        logic       last;
    } result_t;

endpackage

[design/mcrt_in_if.sv]
// Request channel carrying one item from the chain controller.
interface mcrt_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] id_byte;
    logic [7:0] data_byte;
    logic [3:0] position;
    logic [3:0] occurrence;

    modport source (output valid, req_type, id_byte, data_byte, position, occurrence,
                    input ready);
    modport sink (input valid, req_type, id_byte, data_byte, position, occurrence,
                  output ready);
endinterface

[design/mcrt_out_if.sv]
// Result channel carrying status, shift bytes, strobes and answers.
interface mcrt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] shift_byte;
    logic       found;
    logic [7:0] answer_id;
    logic [7:0] answer_input_one;
    logic [7:0] answer_input_two;
    logic [7:0] answer_output;
    logic [4:0] connected_total;
    logic       error_flag;
    logic       last;

    modport source (output valid, kind, shift_byte, found, answer_id, answer_input_one,
                    answer_input_two, answer_output, connected_total, error_flag, last,
                    input ready);
    modport sink (input valid, kind, shift_byte, found, answer_id, answer_input_one,
                  answer_input_two, answer_output, connected_total, error_flag, last,
                  output ready);
endinterface

[design/mcrt_cache.sv]
// Per-module data cache: one write port and one read port.
module mcrt_cache
    import mcrt_pkg::*;
(
    input  logic              clk,
    input  cache_wr_t         wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output cache_entry_t      rd_data
);

    cache_entry_t mem [MAX_CACHED];

    always_ff @(posedge clk)
    begin
        case (wr.op)
            CW_NEW:
            begin
                mem[wr.addr] <= '{id: wr.data, in1: 8'h00, in2: 8'h00, out: 8'h00};
            end
            CW_IN1:
            begin
                mem[wr.addr].in1 <= wr.data;
            end
            CW_IN2:
            begin
                mem[wr.addr].in2 <= wr.data;
            end
            CW_OUT:
            begin
                mem[wr.addr].out <= wr.data;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_data = mem[rd_addr];

endmodule

[design/mcrt_ctrl.sv]
// Sequencer that walks the chain tables with one shared identifier comparator.
module mcrt_ctrl
    import mcrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  req_item_t in_req,
    output logic      in_ready,
    output logic      res_valid,
    output result_t   res,
    input  logic      res_take
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CMP,
        ST_FILL,
        ST_PARK,
        ST_SEARCH,
        ST_COMPACT,
        ST_DONE,
        ST_PUSH,
        ST_NTH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        sb;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } emit_t;

    state_t                 state_reg, state_next;
    state_t                 ret_reg, ret_next;
    emit_t                  em_reg, em_next;
    req_item_t              req_reg, req_next;
    logic [LOOP_W-1:0]      cnt_reg, cnt_next;
    logic [LOOP_W-1:0]      j_reg, j_next;
    logic [LOOP_W-1:0]      seen_reg, seen_next;
    logic                   phase_reg, phase_next;
    logic                   push_reg, push_next;
    logic [CONN_W-1:0]      scan_used_reg, scan_used_next;
    logic [CONN_W-1:0]      conn_used_reg, conn_used_next;
    logic [CACHE_CNT_W-1:0] cache_used_reg, cache_used_next;
    logic [CACHE_CNT_W-1:0] park_used_reg, park_used_next;
    logic                   error_reg, error_next;
    logic [MAX_CACHED-1:0]  valid_reg, valid_next;

    logic [7:0]        scan_ids [MAX_CONNECTED];
    logic [SLOT_W-1:0] conn_slots [MAX_CONNECTED];
    logic [SLOT_W-1:0] park_slots [MAX_CACHED];

    logic                   scan_we;
    logic [CONN_IDX_W-1:0]  scan_waddr;
    logic [7:0]             scan_wdata;
    logic                   conn_we;
    logic [CONN_IDX_W-1:0]  conn_waddr;
    logic [SLOT_W-1:0]      conn_wdata;
    logic                   park_we;
    logic [SLOT_W-1:0]      park_waddr;
    logic [SLOT_W-1:0]      park_wdata;

    logic [CONN_IDX_W-1:0]  conn_raddr;
    logic [SLOT_W-1:0]      conn_rd;
    logic [7:0]             scan_rd;
    logic [SLOT_W-1:0]      park_raddr;
    logic [SLOT_W-1:0]      park_rd;
    logic [SLOT_W-1:0]      cache_raddr;
    cache_entry_t           cache_rd;
    cache_wr_t              cache_wr;
    logic [7:0]             cmp_b;
    logic                   id_match;
    logic [LOOP_W-1:0]      cnt_dec;
    logic [CACHE_CNT_W-1:0] park_dec;
    logic                   pos_hit;
    logic [CONN_W-1:0]      scan_after;
    req_t                   req_code;

    mcrt_cache u_cache (
        .clk     (clk),
        .wr      (cache_wr),
        .rd_addr (cache_raddr),
        .rd_data (cache_rd)
    );

    assign req_code = req_t'(req_reg.req_type);
    assign cnt_dec  = cnt_reg - 1'b1;
    assign park_dec = park_used_reg - 1'b1;
    assign pos_hit  = LOOP_W'(req_reg.position) < LOOP_W'(conn_used_reg);

    always_comb
    begin
        case (state_reg)
            ST_DISPATCH: conn_raddr = CONN_IDX_W'(req_reg.position);
            ST_PUSH:     conn_raddr = cnt_dec[CONN_IDX_W-1:0];
            default:     conn_raddr = cnt_reg[CONN_IDX_W-1:0];
        endcase
        park_raddr = (state_reg == ST_COMPACT) ? park_dec[SLOT_W-1:0] : j_reg[SLOT_W-1:0];
        case (state_reg)
            ST_SEARCH: cache_raddr = park_rd;
            ST_EMIT:   cache_raddr = em_reg.slot;
            default:   cache_raddr = conn_rd;
        endcase
    end

    assign conn_rd  = conn_slots[conn_raddr];
    assign park_rd  = park_slots[park_raddr];
    assign scan_rd  = scan_ids[cnt_reg[CONN_IDX_W-1:0]];
    assign cmp_b    = (state_reg == ST_NTH) ? req_reg.id_byte : scan_rd;
    assign id_match = cache_rd.id == cmp_b;
    assign scan_after = (scan_used_reg < CONN_W'(MAX_CONNECTED)) ?
                        scan_used_reg + 1'b1 : scan_used_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        em_next         = em_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        j_next          = j_reg;
        seen_next       = seen_reg;
        phase_next      = phase_reg;
        push_next       = push_reg;
        scan_used_next  = scan_used_reg;
        conn_used_next  = conn_used_reg;
        cache_used_next = cache_used_reg;
        park_used_next  = park_used_reg;
        error_next      = error_reg;
        valid_next      = valid_reg;
        scan_we         = 1'b0;
        scan_waddr      = scan_used_reg[CONN_IDX_W-1:0];
        scan_wdata      = req_reg.id_byte;
        conn_we         = 1'b0;
        conn_waddr      = conn_used_reg[CONN_IDX_W-1:0];
        conn_wdata      = cache_used_reg[SLOT_W-1:0];
        park_we         = 1'b0;
        park_waddr      = park_used_reg[SLOT_W-1:0];
        park_wdata      = conn_rd;
        cache_wr        = '{op: CW_NONE, addr: conn_rd, data: req_reg.data_byte};
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_req;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                em_next    = '{kind: KIND_STATUS, sb: 8'h00, hit: 1'b0, slot: '0, last: 1'b1};
                ret_next   = ST_IDLE;
                state_next = ST_EMIT;
                case (req_code)
                    REQ_SCAN:
                    begin
                        cnt_next = '0;
                        if (req_reg.id_byte != ID_NONE && req_reg.id_byte != ID_EMPTY)
                        begin
                            scan_we        = scan_used_reg < CONN_W'(MAX_CONNECTED);
                            scan_used_next = scan_after;
                            if (scan_after >= CONN_W'(MAX_CONNECTED))
                            begin
                                state_next = ST_CMP;
                            end
                        end
                        else
                        begin
                            state_next = ST_CMP;
                        end
                    end
                    REQ_IN1, REQ_IN2, REQ_OUT:
                    begin
                        if (pos_hit)
                        begin
                            case (req_code)
                                REQ_IN1: cache_wr.op = CW_IN1;
                                REQ_IN2: cache_wr.op = CW_IN2;
                                default: cache_wr.op = CW_OUT;
                            endcase
                        end
                        em_next.hit  = pos_hit;
                        em_next.slot = conn_rd;
                    end
                    REQ_PUSH:
                    begin
                        cnt_next   = LOOP_W'(conn_used_reg);
                        phase_next = 1'b0;
                        state_next = ST_PUSH;
                    end
                    REQ_QPOS:
                    begin
                        em_next.kind = KIND_ANSWER;
                        em_next.hit  = pos_hit;
                        em_next.slot = conn_rd;
                    end
                    REQ_QNTH:
                    begin
                        cnt_next   = '0;
                        seen_next  = '0;
                        state_next = ST_NTH;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CMP:
            begin
                if (scan_used_reg != conn_used_reg ||
                    (cnt_reg != LOOP_W'(scan_used_reg) && !id_match))
                begin
                    cnt_next   = '0;
                    state_next = (cache_used_reg == '0 && conn_used_reg == '0) ?
                                 ST_FILL : ST_PARK;
                end
                else if (cnt_reg == LOOP_W'(scan_used_reg))
                begin
                    push_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                if (cnt_reg == LOOP_W'(scan_used_reg))
                begin
                    push_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else if (cnt_reg >= LOOP_W'(MAX_CACHED))
                begin
                    error_next = 1'b1;
                    push_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cache_wr        = '{op: CW_NEW, addr: cache_used_reg[SLOT_W-1:0],
                                        data: scan_rd};
                    conn_we         = 1'b1;
                    conn_waddr      = cnt_reg[CONN_IDX_W-1:0];
                    cache_used_next = cache_used_reg + 1'b1;
                    conn_used_next  = conn_used_reg + 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            ST_PARK:
            begin
                if (cnt_reg == LOOP_W'(conn_used_reg))
                begin
                    conn_used_next = '0;
                    cnt_next       = '0;
                    j_next         = '0;
                    state_next     = ST_SEARCH;
                end
                else if (park_used_reg >= CACHE_CNT_W'(MAX_CACHED))
                begin
                    error_next = 1'b1;
                    push_next  = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    park_we                                 = 1'b1;
                    valid_next[park_used_reg[SLOT_W-1:0]]   = 1'b1;
                    park_used_next                          = park_used_reg + 1'b1;
                    cnt_next                                = cnt_reg + 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (cnt_reg == LOOP_W'(scan_used_reg))
                begin
                    cnt_next   = '0;
                    state_next = ST_COMPACT;
                end
                else if (j_reg == LOOP_W'(park_used_reg))
                begin
                    if (cache_used_reg >= CACHE_CNT_W'(MAX_CACHED))
                    begin
                        error_next = 1'b1;
                        push_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cache_wr        = '{op: CW_NEW, addr: cache_used_reg[SLOT_W-1:0],
                                            data: scan_rd};
                        conn_we         = 1'b1;
                        cache_used_next = cache_used_reg + 1'b1;
                        conn_used_next  = conn_used_reg + 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                        j_next          = '0;
                    end
                end
                else if (valid_reg[j_reg[SLOT_W-1:0]] && id_match)
                begin
                    conn_we                         = 1'b1;
                    conn_wdata                      = park_rd;
                    valid_next[j_reg[SLOT_W-1:0]]   = 1'b0;
                    conn_used_next                  = conn_used_reg + 1'b1;
                    cnt_next                        = cnt_reg + 1'b1;
                    j_next                          = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_COMPACT:
            begin
                if (cnt_reg == LOOP_W'(park_used_reg))
                begin
                    push_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!valid_reg[cnt_reg[SLOT_W-1:0]])
                begin
                    park_we                               = 1'b1;
                    park_waddr                            = cnt_reg[SLOT_W-1:0];
                    park_wdata                            = park_rd;
                    valid_next[cnt_reg[SLOT_W-1:0]]       = valid_reg[park_dec[SLOT_W-1:0]];
                    valid_next[park_dec[SLOT_W-1:0]]      = 1'b0;
                    park_used_next                        = park_dec;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                scan_used_next = '0;
                if (push_reg)
                begin
                    cnt_next   = LOOP_W'(conn_used_reg);
                    phase_next = 1'b0;
                    state_next = ST_PUSH;
                end
                else
                begin
                    em_next    = '{kind: KIND_STATUS, sb: 8'h00, hit: 1'b0, slot: '0,
                                   last: 1'b1};
                    ret_next   = ST_IDLE;
                    state_next = ST_EMIT;
                end
            end
            ST_PUSH:
            begin
                state_next = ST_EMIT;
                ret_next   = ST_PUSH;
                if (cnt_reg != '0)
                begin
                    em_next  = '{kind: KIND_SHIFT,
                                 sb: phase_reg ? cache_rd.in2 : cache_rd.in1,
                                 hit: 1'b0, slot: '0, last: 1'b0};
                    cnt_next = cnt_dec;
                end
                else
                begin
                    em_next = '{kind: KIND_STROBE, sb: 8'h00, hit: 1'b0, slot: '0,
                                last: phase_reg};
                    if (phase_reg)
                    begin
                        ret_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        cnt_next   = LOOP_W'(conn_used_reg);
                    end
                end
            end
            ST_NTH:
            begin
                em_next  = '{kind: KIND_ANSWER, sb: 8'h00, hit: 1'b0, slot: '0, last: 1'b1};
                ret_next = ST_IDLE;
                if (cnt_reg == LOOP_W'(conn_used_reg))
                begin
                    state_next = ST_EMIT;
                end
                else if (id_match && seen_reg == LOOP_W'(req_reg.occurrence))
                begin
                    em_next.hit  = 1'b1;
                    em_next.slot = conn_rd;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    if (id_match)
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = state_reg == ST_IDLE;

    always_comb
    begin
        res.kind             = em_reg.kind;
        res.shift_byte       = em_reg.sb;
        res.found            = em_reg.hit;
        res.answer_id        = em_reg.hit ? cache_rd.id : 8'h00;
        res.answer_input_one = em_reg.hit ? cache_rd.in1 : 8'h00;
        res.answer_input_two = em_reg.hit ? cache_rd.in2 : 8'h00;
        res.answer_output    = em_reg.hit ? cache_rd.out : 8'h00;
        res.connected_total  = 5'(conn_used_reg);
        res.error_flag       = error_reg;
        res.last             = em_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            phase_reg      <= 1'b0;
            push_reg       <= 1'b0;
            scan_used_reg  <= '0;
            conn_used_reg  <= '0;
            cache_used_reg <= '0;
            park_used_reg  <= '0;
            error_reg      <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            phase_reg      <= phase_next;
            push_reg       <= push_next;
            scan_used_reg  <= scan_used_next;
            conn_used_reg  <= conn_used_next;
            cache_used_reg <= cache_used_next;
            park_used_reg  <= park_used_next;
            error_reg      <= error_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_reg   <= em_next;
        req_reg  <= req_next;
        cnt_reg  <= cnt_next;
        j_reg    <= j_next;
        seen_reg <= seen_next;
    end

    always_ff @(posedge clk)
    begin
        if (scan_we)
        begin
            scan_ids[scan_waddr] <= scan_wdata;
        end
        if (conn_we)
        begin
            conn_slots[conn_waddr] <= conn_wdata;
        end
        if (park_we)
        begin
            park_slots[park_waddr] <= park_wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        conn_used_reg <= CONN_W'(MAX_CONNECTED))
        else $error("Connected count exceeds the chain length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cache_used_reg <= CACHE_CNT_W'(MAX_CACHED) &&
        park_used_reg <= CACHE_CNT_W'(MAX_CACHED))
        else $error("Cache or parked count exceeds the cache size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(error_reg) |-> error_reg)
        else $error("Sticky error was cleared.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid) |=> (state_reg == ST_DISPATCH && !res_valid))
        else $error("Accepted item did not start dispatch.");

endmodule

[design/module_chain_remap_table.sv]
// Top level of the module chain remap table with its result register.
// A status or answer item goes through dispatch and emit to its result; an nth query
// walks positions first; a push shifts in1 then in2 bytes, each run ending in a strobe.
// A remap walks compare, fill or park, search and compaction, one table entry a cycle.
// Throughput: one item at a time; the next item is taken once the last result is queued.
// Reset clears all counts and the sticky error; the table contents need no clearing.
module module_chain_remap_table
    import mcrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mcrt_in_if.sink    in_item,
    mcrt_out_if.source out_item
);

    req_item_t in_req;
    result_t   res;
    logic      res_valid;
    logic      res_take;
    logic      out_valid_reg;
    result_t   out_reg;

    assign in_req = '{req_type: in_item.req_type, id_byte: in_item.id_byte,
                      data_byte: in_item.data_byte, position: in_item.position,
                      occurrence: in_item.occurrence};

    mcrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_req    (in_req),
        .in_ready  (in_item.ready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    assign res_take = res_valid && (!out_valid_reg || out_item.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_item.valid            = out_valid_reg;
    assign out_item.kind             = out_reg.kind;
    assign out_item.shift_byte       = out_reg.shift_byte;
    assign out_item.found            = out_reg.found;
    assign out_item.answer_id        = out_reg.answer_id;
    assign out_item.answer_input_one = out_reg.answer_input_one;
    assign out_item.answer_input_two = out_reg.answer_input_two;
    assign out_item.answer_output    = out_reg.answer_output;
    assign out_item.connected_total  = out_reg.connected_total;
    assign out_item.error_flag       = out_reg.error_flag;
    assign out_item.last             = out_reg.last;

endmodule
